>>> design/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
package stbs_pkg;

    localparam int SLOT_W  = 10;
    localparam int TEXT_W  = 64;
    localparam int NUM_W   = 32;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 11;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;

    // Request operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Register index (paddr[2])
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // Microcode program steps
    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_PROBE,
        S_EMIT
    } t_step;

    // Jump conditions
    typedef enum logic [1:0] {
        C_REQ,
        C_LOAD,
        C_DONE,
        C_OUT_BUSY
    } t_cond;

    // One control word of the program
    typedef struct packed {
        t_cond cond;
        t_step jmp_true;
        t_step jmp_false;
        logic  idle;
        logic  init;
        logic  write;
        logic  probe;
        logic  emit;
    } t_uword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic req;
        logic is_load;
        logic done;
        logic out_busy;
    } t_flags;

endpackage

>>> design/sorted_table_binary_search_top.sv
// Top level of the sorted-table binary search block: datapath, table memory, APB register.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready) carries one load or one search.
//   A load writes text key, number key and record position into i_slot and
//   gives no response; it is accepted, then written in the setup step.
//   A search runs a binary search over slots 0 .. entry_count-1 (entry_count
//   clamped to TABLE_DEPTH) on the text key (unsigned) or number key (signed)
//   and gives one response on (o_rsp_valid / i_rsp_ready): found flag,
//   stored position and slot of the match, both 0 on a miss.
//   A search runs through the setup step, P probe steps and the emit step,
//   P being the probe count: 1 for an empty table,
//   at most floor(log2(count)) + 1 (11 for 1024 entries).
//   One probe per cycle: the registered read of the table memory bounds it,
//   with the next midpoint for both outcomes prepared beside the compare.
//   The response register frees the engine: the next request is taken while
//   a response waits; a search only stalls in its last step until the
//   response register is free.
//   The user writes entry_count over APB at byte address 0 only while idle; not enforced.
//   Reset clears entry_count, the sequencer and the response valid; the table
//   keeps no reset and must be loaded before it is searched.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic                                i_operation,
    input  logic [stbs_pkg::SLOT_W-1:0]         i_slot,
    input  logic [stbs_pkg::TEXT_W-1:0]         i_text_key,
    input  logic signed [stbs_pkg::NUM_W-1:0]   i_number_key,
    input  logic [stbs_pkg::POS_W-1:0]          i_record_position,
    input  logic                                i_key_is_text,
    // response channel
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_ready,
    output logic                                o_found,
    output logic [stbs_pkg::POS_W-1:0]          o_matched_position,
    output logic [stbs_pkg::SLOT_W-1:0]         o_matched_slot,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stbs_pkg::PADDR_W-1:0]        paddr,
    input  logic [stbs_pkg::APB_DW-1:0]         pwdata,
    output logic [stbs_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);          // slot index width
    localparam int IW = AW + 1;                        // range bounds, hold TABLE_DEPTH
    localparam int TW = 8 * KEY_CHARS;                 // kept text key bits
    localparam int MW = (IW > COUNT_W) ? IW : COUNT_W; // count clamp compare width
    localparam int SW = (IW > SLOT_W) ? IW : SLOT_W;   // slot range compare width

    // ---------------- control ----------------
    t_uword uword;
    t_flags flags;

    // ---------------- configuration ----------------
    logic [COUNT_W-1:0] r_entry_count;
    logic               cfg_wr;

    // ---------------- captured request ----------------
    logic                    r_op;
    logic [SLOT_W-1:0]       r_slot;
    logic [TW-1:0]           r_tkey;
    logic signed [NUM_W-1:0] r_nkey;
    logic [POS_W-1:0]        r_pos;
    logic                    r_by_text;

    // ---------------- table memory ----------------
    logic [TW-1:0]           mem_text [TABLE_DEPTH];
    logic [NUM_W-1:0]        mem_num  [TABLE_DEPTH];
    logic [POS_W-1:0]        mem_pos  [TABLE_DEPTH];
    logic [TW-1:0]           r_rd_text;
    logic signed [NUM_W-1:0] r_rd_num;
    logic [POS_W-1:0]        r_rd_pos;
    logic [AW-1:0]           rd_addr;
    logic [SW-1:0]           slot_ext;
    logic                    slot_ok;

    // ---------------- search state ----------------
    logic [IW-1:0] r_lo;
    logic [IW-1:0] r_end;    // exclusive upper bound
    logic [AW-1:0] r_mid;
    logic          r_hit;
    logic [POS_W-1:0] r_hpos;
    logic [AW-1:0]    r_hslot;

    logic [MW-1:0] count_ext;
    logic [IW-1:0] cnt;
    logic [IW-1:0] cnt_m1;
    logic [AW-1:0] mid_init;
    logic [IW-1:0] mid_ext;
    logic [IW-1:0] lo_r;
    logic [IW:0]   sum_r;
    logic [IW:0]   sum_l;
    logic [AW-1:0] mid_r;
    logic [AW-1:0] mid_l;
    logic          rec_lt;
    logic          rec_eq;
    logic          cur_empty;
    logic          hit;
    logic          next_empty;

    // ---------------- response ----------------
    logic              r_out_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_mpos;
    logic [SLOT_W-1:0] r_mslot;
    logic              out_busy;
    logic              accept;

    stbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword)
    );

    // Handshake: take a request only at the idle step of the program.
    assign o_req_ready = uword.idle;
    assign accept      = i_req_valid && o_req_ready;
    assign out_busy    = r_out_valid && !i_rsp_ready;

    assign flags = '{req:      i_req_valid,
                     is_load:  (r_op == OP_LOAD),
                     done:     cur_empty || hit || next_empty,
                     out_busy: out_busy};

    // APB: single register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(r_entry_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_wr) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Capture the request; only the top KEY_CHARS bytes of the text key count.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_slot    <= i_slot;
            r_tkey    <= i_text_key[TEXT_W-1 -: TW];
            r_nkey    <= i_number_key;
            r_pos     <= i_record_position;
            r_by_text <= i_key_is_text;
        end
    end

    // Clamp the count to the table size and find the first midpoint.
    always_comb begin
        count_ext = MW'(r_entry_count);
        cnt       = (count_ext > MW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(count_ext);
        cnt_m1    = cnt - IW'(1);
        mid_init  = cnt_m1[AW:1];
    end

    // Probe compare, with both next midpoints prepared alongside.
    always_comb begin
        if (r_by_text) begin
            rec_lt = r_rd_text < r_tkey;
            rec_eq = r_rd_text == r_tkey;
        end else begin
            rec_lt = r_rd_num < r_nkey;
            rec_eq = r_rd_num == r_nkey;
        end
        cur_empty  = r_lo >= r_end;
        hit        = !cur_empty && rec_eq;
        mid_ext    = IW'(r_mid);
        lo_r       = mid_ext + IW'(1);
        sum_r      = (IW + 1)'(mid_ext) + (IW + 1)'(r_end);
        sum_l      = (IW + 1)'(r_lo) + (IW + 1)'(mid_ext) - (IW + 1)'(1);
        mid_r      = sum_r[AW:1];
        mid_l      = sum_l[AW:1];
        next_empty = rec_lt ? (lo_r >= r_end) : (r_lo >= mid_ext);
        rd_addr    = uword.init ? mid_init : (rec_lt ? mid_r : mid_l);
    end

    // Advance the search range; hold the match when it is seen.
    always_ff @(posedge i_clk) begin
        if (uword.init) begin
            r_lo  <= '0;
            r_end <= cnt;
            r_mid <= mid_init;
            r_hit <= 1'b0;
        end else if (uword.probe) begin
            if (hit) begin
                r_hit   <= 1'b1;
                r_hpos  <= r_rd_pos;
                r_hslot <= r_mid;
            end else if (rec_lt) begin
                r_lo  <= lo_r;
                r_mid <= mid_r;
            end else begin
                r_end <= mid_ext;
                r_mid <= mid_l;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    assign slot_ext = SW'(r_slot);
    assign slot_ok  = slot_ext < SW'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (uword.write && (r_op == OP_LOAD) && slot_ok) begin
            mem_text[slot_ext[AW-1:0]] <= r_tkey;
            mem_num[slot_ext[AW-1:0]]  <= r_nkey;
            mem_pos[slot_ext[AW-1:0]]  <= r_pos;
        end
        r_rd_text <= mem_text[rd_addr];
        r_rd_num  <= mem_num[rd_addr];
        r_rd_pos  <= mem_pos[rd_addr];
    end

    // Response register: load when free, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uword.emit && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uword.emit && !out_busy) begin
            r_found <= r_hit;
            r_mpos  <= r_hit ? r_hpos : '0;
            r_mslot <= r_hit ? SLOT_W'(r_hslot) : '0;
        end
    end

    assign o_rsp_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_matched_position = r_mpos;
    assign o_matched_slot     = r_mslot;

    // ---------------- assertions ----------------
    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uword.probe |-> (r_lo <= r_end))
        else $error("search range bounds crossed");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (IW'(r_hslot) < cnt))
        else $error("match reported outside the counted range");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_req_ready)
        else $error("request accepted while another is in work");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uword.emit && out_busy) |=> (uword.emit && $stable(r_mpos)))
        else $error("response overwritten while stalled");

endmodule

>>> design/stbs_seq.sv
// Microcode sequencer: program counter, control-word ROM and jump logic.
module stbs_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stbs_pkg::t_flags i_flags,
    output stbs_pkg::t_uword o_uword
);
    import stbs_pkg::*;

    t_step r_pc;
    t_step n_pc;
    logic  take;

    function automatic t_uword rom(input t_step pc);
        t_uword w;
        w = '{cond: C_REQ, jmp_true: S_IDLE, jmp_false: S_IDLE,
              idle: 1'b0, init: 1'b0, write: 1'b0, probe: 1'b0, emit: 1'b0};
        case (pc)
            S_IDLE: begin
                // wait for a request
                w.cond      = C_REQ;
                w.jmp_true  = S_SETUP;
                w.jmp_false = S_IDLE;
                w.idle      = 1'b1;
            end
            S_SETUP: begin
                // write a load record, or open the search range
                w.cond      = C_LOAD;
                w.jmp_true  = S_IDLE;
                w.jmp_false = S_PROBE;
                w.init      = 1'b1;
                w.write     = 1'b1;
            end
            S_PROBE: begin
                w.cond      = C_DONE;
                w.jmp_true  = S_EMIT;
                w.jmp_false = S_PROBE;
                w.probe     = 1'b1;
            end
            S_EMIT: begin
                w.cond      = C_OUT_BUSY;
                w.jmp_true  = S_EMIT;
                w.jmp_false = S_IDLE;
                w.emit      = 1'b1;
            end
            default: begin
                w.cond      = C_REQ;
                w.jmp_true  = S_IDLE;
                w.jmp_false = S_IDLE;
            end
        endcase
        return w;
    endfunction

    always_comb begin
        o_uword = rom(r_pc);
        case (o_uword.cond)
            C_REQ:      take = i_flags.req;
            C_LOAD:     take = i_flags.is_load;
            C_DONE:     take = i_flags.done;
            C_OUT_BUSY: take = i_flags.out_busy;
            default:    take = 1'b0;
        endcase
        n_pc = take ? o_uword.jmp_true : o_uword.jmp_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> tb/stbs_lookup_check.sv
// Watches the sorted-table search channels, predicts every search response and compares it.
`timescale 1ns / 1ps

module stbs_lookup_check #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    input  logic                                i_operation,
    input  logic [stbs_pkg::SLOT_W-1:0]         i_slot,
    input  logic [stbs_pkg::TEXT_W-1:0]         i_text_key,
    input  logic signed [stbs_pkg::NUM_W-1:0]   i_number_key,
    input  logic [stbs_pkg::POS_W-1:0]          i_record_position,
    input  logic                                i_key_is_text,
    input  logic                                i_rsp_valid,
    input  logic                                i_rsp_ready,
    input  logic                                i_found,
    input  logic [stbs_pkg::POS_W-1:0]          i_matched_position,
    input  logic [stbs_pkg::SLOT_W-1:0]         i_matched_slot,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stbs_pkg::PADDR_W-1:0]        paddr,
    input  logic [stbs_pkg::APB_DW-1:0]         pwdata,
    input  logic [stbs_pkg::APB_DW-1:0]         prdata,
    input  logic                                pready,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import stbs_pkg::*;

    localparam logic [TEXT_W-1:0] TEXT_MASK = ~(TEXT_W'(0)) << (TEXT_W - 8 * KEY_CHARS);

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [SLOT_W-1:0] slot;
    } t_lookup_result;

    logic [TEXT_W-1:0]       text_keys   [TABLE_DEPTH];
    logic signed [NUM_W-1:0] number_keys [TABLE_DEPTH];
    logic [POS_W-1:0]        positions   [TABLE_DEPTH];
    logic [COUNT_W-1:0]      entry_count;
    t_lookup_result          expected_lookups [$];
    int                      fails = 0;

    task automatic flag_error(input string msg);
        fails++;
        if (fails <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Walk the same probe sequence as the block; stop at the first equal key.
    function automatic t_lookup_result binary_lookup(input logic by_text,
                                                     input logic [TEXT_W-1:0] tkey,
                                                     input logic signed [NUM_W-1:0] nkey);
        t_lookup_result res;
        int lo, hi, mid;
        logic below, above;
        res = '0;
        lo  = 0;
        hi  = ((entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count)) - 1;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (by_text) begin
                below = text_keys[mid] < tkey;
                above = text_keys[mid] > tkey;
            end else begin
                below = number_keys[mid] < nkey;
                above = number_keys[mid] > nkey;
            end
            if (!below && !above) begin
                res.found    = 1'b1;
                res.position = positions[mid];
                res.slot     = SLOT_W'(mid);
            end else if (below) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            entry_count = '0;
            expected_lookups.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == REG_ENTRY_COUNT) begin
                if (pwrite) begin
                    entry_count = pwdata[COUNT_W-1:0];
                end else if (prdata !== APB_DW'(entry_count)) begin
                    flag_error($sformatf("entry_count readback: expected %0d, got %0h",
                                         entry_count, prdata));
                end
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_lookups.size() == 0) begin
                    flag_error($sformatf("response with no search outstanding: %0b/%0h/%0d",
                                         i_found, i_matched_position, i_matched_slot));
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_found !== want.found || i_matched_position !== want.position ||
                        i_matched_slot !== want.slot) begin
                        flag_error($sformatf({"search response: expected found %0b pos %0h ",
                                              "slot %0d, got found %0b pos %0h slot %0d"},
                                             want.found, want.position, want.slot,
                                             i_found, i_matched_position, i_matched_slot));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_operation == OP_SEARCH) begin
                    expected_lookups.push_back(binary_lookup(i_key_is_text,
                                                             i_text_key & TEXT_MASK,
                                                             i_number_key));
                end else if (i_slot < TABLE_DEPTH) begin
                    text_keys[i_slot]   = i_text_key & TEXT_MASK;
                    number_keys[i_slot] = i_number_key;
                    positions[i_slot]   = i_record_position;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_lookups.size();
    end

endmodule

>>> tb/sorted_table_binary_search_top_tb.sv
// Testbench top for the sorted-table binary search block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module sorted_table_binary_search_top_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int KEY_CHARS    = 8;
    localparam int RANDOM_ITEMS = 300;
    localparam int SETTLE       = 8;        // margin for a trailing load to finish its write
    localparam int CYCLE_LIMIT  = 1000000;

    // Packed text keys for the directed part, first character in the top byte
    localparam logic [TEXT_W-1:0] KEY_A    = 64'h6100_0000_0000_0000;  // "a"
    localparam logic [TEXT_W-1:0] KEY_AB   = 64'h6162_0000_0000_0000;  // "ab"
    localparam logic [TEXT_W-1:0] KEY_NAME = 64'h6E61_6D65_0000_0000;  // "name"
    localparam logic [TEXT_W-1:0] TEXT_MAX = '1;
    localparam logic signed [NUM_W-1:0] NUM_MIN = 32'sh8000_0000;
    localparam logic signed [NUM_W-1:0] NUM_MAX = 32'sh7FFF_FFFF;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_req_valid;
    logic                    o_req_ready;
    logic                    i_operation;
    logic [SLOT_W-1:0]       i_slot;
    logic [TEXT_W-1:0]       i_text_key;
    logic signed [NUM_W-1:0] i_number_key;
    logic [POS_W-1:0]        i_record_position;
    logic                    i_key_is_text;
    logic                    o_rsp_valid;
    logic                    i_rsp_ready;
    logic                    o_found;
    logic [POS_W-1:0]        o_matched_position;
    logic [SLOT_W-1:0]       o_matched_slot;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    int fail_count;
    int pending;
    int cycles = 0;
    int sent   = 0;
    bit req_calm = 1'b0;
    bit rsp_calm = 1'b0;

    // Keys as last loaded, so searches can aim at real entries
    logic [TEXT_W-1:0]       table_text [TABLE_DEPTH];
    logic signed [NUM_W-1:0] table_num  [TABLE_DEPTH];

    sorted_table_binary_search_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_req_valid),
        .o_req_ready        (o_req_ready),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_text_key         (i_text_key),
        .i_number_key       (i_number_key),
        .i_record_position  (i_record_position),
        .i_key_is_text      (i_key_is_text),
        .o_rsp_valid        (o_rsp_valid),
        .i_rsp_ready        (i_rsp_ready),
        .o_found            (o_found),
        .o_matched_position (o_matched_position),
        .o_matched_slot     (o_matched_slot),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    stbs_lookup_check #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) u_lookup_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_req_valid),
        .i_req_ready        (o_req_ready),
        .i_operation        (i_operation),
        .i_slot             (i_slot),
        .i_text_key         (i_text_key),
        .i_number_key       (i_number_key),
        .i_record_position  (i_record_position),
        .i_key_is_text      (i_key_is_text),
        .i_rsp_valid        (o_rsp_valid),
        .i_rsp_ready        (i_rsp_ready),
        .i_found            (o_found),
        .i_matched_position (o_matched_position),
        .i_matched_slot     (o_matched_slot),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost response ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sorted_table_binary_search_top_tb: errors");
            $finish;
        end
    end

    // Wait before the next item: drawn at random, with stretches of back-to-back traffic.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // Response side: stall at random, also while nothing is on offer.
    initial begin
        int hold;
        i_rsp_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = draw_wait(rsp_calm);
            if (hold > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_rsp_valid && i_rsp_ready));
        end
    end

    // Offer one request and hold it until the block takes it. Valid stays high on
    // return, so a request with no gap follows without a bubble.
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic [TEXT_W-1:0] tkey,
                                input logic signed [NUM_W-1:0] nkey,
                                input logic [POS_W-1:0] pos, input logic by_text);
        int gap;
        gap = draw_wait(req_calm);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation       <= op;
        i_slot            <= slot;
        i_text_key        <= tkey;
        i_number_key      <= nkey;
        i_record_position <= pos;
        i_key_is_text     <= by_text;
        i_req_valid       <= 1'b1;
        do @(posedge i_clk); while (!(i_req_valid && o_req_ready));
        sent++;
        if (op == OP_LOAD) begin
            table_text[slot] = tkey;
            table_num[slot]  = nkey;
        end
    endtask

    // Drop valid and let the block go idle: every response taken, then let a
    // trailing load finish its write.
    task automatic settle();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write entry_count over APB, then read it back for the register check.
    task automatic set_entry_count(input int unsigned count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRY_COUNT, 2'b00};
        pwdata  <= APB_DW'(count);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load slots 0 .. n-1 with keys ascending in both text and number order, so
    // either search mode sees a sorted table. Some runs pin the ends to the key
    // extremes; some neighbors share a key.
    task automatic load_sorted_prefix(input int n);
        logic [TEXT_W-1:0]       tspan, tk;
        longint                  nspan;
        logic [63:0]             nv;
        logic signed [NUM_W-1:0] nk;
        bit                      pin_ends;
        tspan    = 64'hFFFF_FFFF_FFFF_FFFF / (n + 1);
        nspan    = 64'sd4294967296 / (n + 1);
        pin_ends = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++) begin
            tk = 64'(i) * tspan + ({$urandom, $urandom} % tspan);
            nv = 64'hFFFF_FFFF_8000_0000 + 64'(i) * nspan + ($urandom % nspan);
            nk = nv[NUM_W-1:0];
            if (i > 0 && $urandom_range(0, 7) == 0) begin
                tk = table_text[i-1];
                nk = table_num[i-1];
            end
            if (pin_ends && i == 0) begin
                tk = '0;
                nk = NUM_MIN;
            end else if (pin_ends && i == n - 1) begin
                tk = TEXT_MAX;
                nk = NUM_MAX;
            end
            send_request(OP_LOAD, SLOT_W'(i), tk, nk, POS_W'($urandom), $urandom_range(0, 1));
        end
    endtask

    // One random request against a table of n entries: mostly searches that hit a
    // stored key, near misses and wild keys, plus stray loads that may break order.
    task automatic random_request(input int n, input int noise_pct);
        int                      r, s, live;
        logic                    by_text;
        logic [TEXT_W-1:0]       tk;
        logic signed [NUM_W-1:0] nk;
        r       = $urandom_range(0, 99);
        by_text = $urandom_range(0, 1);
        tk      = {$urandom, $urandom};
        nk      = $urandom;
        live    = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
        if (r < noise_pct) begin
            send_request(OP_LOAD, SLOT_W'($urandom), tk, nk, POS_W'($urandom), by_text);
        end else begin
            if (live > 0 && r < 65) begin
                s = $urandom_range(0, live - 1);
                if (by_text) tk = table_text[s];
                else nk = table_num[s];
            end else if (live > 0 && r < 80) begin
                s = $urandom_range(0, live - 1);
                if ($urandom_range(0, 1)) begin
                    tk = table_text[s] + 1;
                    nk = table_num[s] + 1;
                end else begin
                    tk = table_text[s] - 1;
                    nk = table_num[s] - 1;
                end
            end else if (r < 86) begin
                tk = $urandom_range(0, 1) ? TEXT_MAX : '0;
                nk = $urandom_range(0, 1) ? NUM_MAX : NUM_MIN;
            end
            send_request(OP_SEARCH, SLOT_W'($urandom), tk, nk, POS_W'($urandom), by_text);
        end
    endtask

    task automatic search_burst(input int n, input int count, input int noise_pct);
        repeat (count) random_request(n, noise_pct);
    endtask

    initial begin
        int mark, n, pick;

        // hold every input at a known value from time zero
        i_rst_n           <= 1'b0;
        i_req_valid       <= 1'b0;
        i_operation       <= OP_LOAD;
        i_slot            <= '0;
        i_text_key        <= '0;
        i_number_key      <= '0;
        i_record_position <= '0;
        i_key_is_text     <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table after reset: both modes must miss.
        send_request(OP_SEARCH, '1, KEY_A, 32'sd0, '1, 1'b1);
        send_request(OP_SEARCH, '0, '0, NUM_MIN, '0, 1'b0);

        // Four sorted records spanning the key extremes, plus the top slot.
        send_request(OP_LOAD, 10'd0, '0, NUM_MIN, 16'h0000, 1'b0);
        send_request(OP_LOAD, 10'd1, KEY_A, 32'sd0, 16'h0A0A, 1'b1);
        send_request(OP_LOAD, 10'd2, KEY_NAME, 32'sd5, 16'h5555, 1'b0);
        send_request(OP_LOAD, 10'd3, TEXT_MAX, NUM_MAX, 16'hFFFF, 1'b1);
        send_request(OP_LOAD, 10'd1023, {$urandom, $urandom}, $urandom, 16'h8001, 1'b0);
        settle();
        set_entry_count(4);

        // hit every record by text, the number extremes and the value 5, then a miss in each mode
        send_request(OP_SEARCH, '0, '0, 32'sd7, '0, 1'b1);
        send_request(OP_SEARCH, '0, KEY_A, 32'sd7, '0, 1'b1);
        send_request(OP_SEARCH, '1, KEY_NAME, 32'sd7, '1, 1'b1);
        send_request(OP_SEARCH, '0, TEXT_MAX, 32'sd7, '0, 1'b1);
        send_request(OP_SEARCH, '0, KEY_AB, NUM_MIN, '0, 1'b0);
        send_request(OP_SEARCH, '0, KEY_AB, NUM_MAX, '0, 1'b0);
        send_request(OP_SEARCH, '0, KEY_AB, 32'sd5, '0, 1'b0);
        send_request(OP_SEARCH, '0, KEY_AB, 32'sd5, '0, 1'b1);
        send_request(OP_SEARCH, '0, KEY_NAME, -32'sd1, '0, 1'b0);
        settle();
        set_entry_count(1);
        send_request(OP_SEARCH, '0, '0, NUM_MAX, '0, 1'b1);
        send_request(OP_SEARCH, '0, '0, NUM_MAX, '0, 1'b0);

        // Full table once, then large counts: exact depth, the register maximum
        // (clamped by the block), and random sizes above and below the depth.
        settle();
        set_entry_count(TABLE_DEPTH);
        load_sorted_prefix(TABLE_DEPTH);
        search_burst(TABLE_DEPTH, 40, 2);
        settle();
        set_entry_count(2047);
        search_burst(2047, 40, 2);
        settle();
        n = $urandom_range(TABLE_DEPTH + 1, 2046);
        set_entry_count(n);
        search_burst(n, 30, 2);
        settle();
        n = $urandom_range(41, TABLE_DEPTH - 1);
        set_entry_count(n);
        search_burst(n, 30, 4);

        // Bulk of the run: small tables, reloaded sorted each time, with searches
        // and some stray loads on top.
        mark = sent;
        while (sent - mark < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            n    = (pick < 3) ? pick : $urandom_range(3, 40);
            settle();
            set_entry_count(n);
            load_sorted_prefix(n);
            search_burst(n, $urandom_range(20, 50), 6);
        end

        settle();
        if (fail_count == 0) begin
            $display("sorted_table_binary_search_top_tb: clean");
        end else begin
            $display("sorted_table_binary_search_top_tb: errors");
        end
        $finish;
    end

endmodule
